[src/tmwf_pkg.sv]
`default_nettype none

package tmwf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CHAN_W   = 2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_READ,
    S_TRIM,
    S_DIV,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[src/tmwf_ram.sv]
`default_nettype none

module tmwf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[src/trimmed_mean_window_filter_unit.sv]
// Per request: the sample is written, the channel's window is read back, the sum is trimmed,
//   scaled by a reciprocal multiply and registered for output (out-of-range channels give 0).
// Flow: requests are taken one at a time, set by the window walk over the single
//   RAM read port; a stalled result holds the next request back in the output state.
// Reset: asynchronous, active low; afterwards all min(CHANNELS,4) * WINDOW words of the
//   window RAM are zeroed, during which s_axis_tready_o stays low.
`default_nettype none

module trimmed_mean_window_filter_unit
  import tmwf_pkg::*;
#(
  parameter int unsigned CHANNELS = 4,
  parameter int unsigned WINDOW   = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [SAMPLE_W-1:0] s_axis_tdata_i,   // [15:0] sample
  input  wire logic [CHAN_W-1:0]   s_axis_tuser_i,   // [1:0] channel
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [SAMPLE_W-1:0]      m_axis_tdata_o    // [15:0] filtered
);

  localparam int unsigned USED_CH = (CHANNELS < 4) ? CHANNELS : 4;
  localparam int unsigned DEPTH   = USED_CH * WINDOW;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CIW     = (USED_CH > 1) ? $clog2(USED_CH) : 1;
  localparam int unsigned PW      = $clog2(WINDOW);
  localparam int unsigned RCW     = $clog2(WINDOW + 1);
  localparam int unsigned SUMW    = 17 + $clog2(WINDOW);
  localparam int unsigned RSH     = 25;
  localparam int unsigned RCPW    = RSH + 1;
  localparam int unsigned PRODW   = SUMW + RCPW;

  localparam longint unsigned RECIP_L =
    ((64'd1 << RSH) + 64'(WINDOW) - 64'd3) / 64'(WINDOW - 2);

  localparam logic [AW-1:0]   WIN_A  = AW'(WINDOW);
  localparam logic [AW-1:0]   LAST_A = AW'(DEPTH - 1);
  localparam logic [PW-1:0]   LAST_P = PW'(WINDOW - 1);
  localparam logic [RCW-1:0]  WIN_R  = RCW'(WINDOW);
  localparam logic [RCPW-1:0] RECIP  = RCPW'(RECIP_L);

  state_e state_q, state_d;

  logic [AW-1:0]       clr_cnt_q;
  logic [PW-1:0]       ptr_q [USED_CH];
  logic [RCW-1:0]      rd_cnt_q;
  logic                m_valid_q;

  logic [SAMPLE_W-1:0] sample_q;
  logic [CIW-1:0]      ch_q;
  logic                ch_ok_q;
  logic [SUMW-1:0]     sum_q;
  logic [SAMPLE_W-1:0] hi_q, lo_q;
  logic                neg_q;
  logic [SUMW-1:0]     mag_q;
  logic [SAMPLE_W-1:0] quo_q;
  logic [SAMPLE_W-1:0] m_data_q;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0] mem_wdata, mem_rdata;

  logic                s_acc, out_free, in_ok;
  logic [AW-1:0]       base_addr;
  logic [SUMW-1:0]     elem_ext, hi_ext, lo_ext, diff;
  logic [PRODW-1:0]    prod;
  logic [SAMPLE_W-1:0] result;

  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign in_ok     = 32'(s_axis_tuser_i) < CHANNELS;
  assign base_addr = AW'(ch_q) * WIN_A;
  assign elem_ext  = {{(SUMW - SAMPLE_W){mem_rdata[SAMPLE_W-1]}}, mem_rdata};
  assign hi_ext    = {{(SUMW - SAMPLE_W){hi_q[SAMPLE_W-1]}}, hi_q};
  assign lo_ext    = {{(SUMW - SAMPLE_W){lo_q[SAMPLE_W-1]}}, lo_q};
  assign diff      = sum_q - hi_ext - lo_ext;
  assign prod      = PRODW'(mag_q) * PRODW'(RECIP);
  assign result    = neg_q ? (~quo_q + 1'b1) : quo_q;

  tmwf_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_cnt_q == LAST_A) state_d = S_IDLE;
      S_IDLE:  if (s_acc) state_d = in_ok ? S_WRITE : S_DONE;
      S_WRITE: state_d = S_READ;
      S_READ:  if (rd_cnt_q == WIN_R) state_d = S_TRIM;
      S_TRIM:  state_d = S_DIV;
      S_DIV:   state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = base_addr + AW'(ptr_q[ch_q]);
    mem_wdata       = sample_q;
    mem_raddr       = base_addr + AW'(rd_cnt_q[PW-1:0]);
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      S_IDLE:  s_axis_tready_o = 1'b1;
      S_WRITE: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      rd_cnt_q  <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < USED_CH; i++) begin
        ptr_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: clr_cnt_q <= clr_cnt_q + 1'b1;
        S_WRITE: begin
          ptr_q[ch_q] <= (ptr_q[ch_q] == LAST_P) ? '0 : ptr_q[ch_q] + 1'b1;
          rd_cnt_q    <= '0;
        end
        S_READ:  rd_cnt_q <= rd_cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          sample_q <= s_axis_tdata_i;
          ch_q     <= CIW'(s_axis_tuser_i);
          ch_ok_q  <= in_ok;
          quo_q    <= '0;
          neg_q    <= 1'b0;
        end
      end
      S_READ: begin
        if (rd_cnt_q == RCW'(1)) begin
          sum_q <= elem_ext;
          hi_q  <= mem_rdata;
          lo_q  <= mem_rdata;
        end else if (rd_cnt_q != '0) begin
          sum_q <= sum_q + elem_ext;
          if ($signed(mem_rdata) > $signed(hi_q)) hi_q <= mem_rdata;
          if ($signed(mem_rdata) < $signed(lo_q)) lo_q <= mem_rdata;
        end
      end
      S_TRIM: begin
        neg_q <= diff[SUMW-1];
        mag_q <= diff[SUMW-1] ? (~diff + 1'b1) : diff;
      end
      S_DIV:  quo_q <= prod[RSH +: SAMPLE_W];
      S_DONE: if (out_free) m_data_q <= ch_ok_q ? result : '0;
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

[src/tmwf_checker.sv]
`default_nettype none

module tmwf_checker
  import tmwf_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic [SAMPLE_W-1:0] s_axis_tdata_i,
  input wire logic [CHAN_W-1:0]   s_axis_tuser_i,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [SAMPLE_W-1:0] m_axis_tdata_o
);

  logic s_acc;
  logic unused_in;

  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign unused_in = ^{s_axis_tdata_i, s_axis_tuser_i};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("request taken while another is in flight");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared too soon after request");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result produced while idle");

endmodule

bind trimmed_mean_window_filter_unit tmwf_checker u_tmwf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

`default_nettype wire
